/* rtl/core/arplm_pkg.sv */
package arplm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TALLY_BITS_DEF  = 32;

  localparam logic FUNC_ACCUM  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic res_load;
  } cmd_t;

endpackage

/* rtl/core/arplm_in_if.sv */
interface arplm_in_if #(
  parameter int SAMPLE_BITS = arplm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

/* rtl/core/arplm_out_if.sv */
interface arplm_out_if #(
  parameter int SAMPLE_BITS = arplm_pkg::SAMPLE_BITS_DEF,
  parameter int TALLY_BITS  = arplm_pkg::TALLY_BITS_DEF
);
  localparam int MsBits = 2 * (SAMPLE_BITS - 1) + 1;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] rms_level;
  logic [MsBits-1:0]      mean_square;
  logic [SAMPLE_BITS-1:0] peak_level;
  logic [TALLY_BITS-1:0]  sample_total;

  modport source (output valid, output rms_level, output mean_square, output peak_level,
                  output sample_total, input ready);
  modport sink (input valid, input rms_level, input mean_square, input peak_level,
                input sample_total, output ready);
endinterface

/* rtl/core/audio_rms_peak_level_meter.sv */
// Audio RMS and peak level meter.
// The input channel carries one item per transfer: func selects between
// accumulating a signed PCM sample and requesting a report. An accumulate
// transfer leaves the block idle with ready held high, so samples stream at
// one per cycle while no report is in progress. The square is registered
// in sq_r and added to the running sum from there, ahead of any report.
// A report drops ready while a restoring divider forms the mean square
// and a bit-serial square root forms the RMS level; the report runs through
// the divider load, divide steps, root load, root steps and result step, in
// that order.
// The result channel presents rms_level, mean_square, peak_level and
// sample_total from an output register. While the receiver stalls, the
// block keeps taking samples while idle; a further report waits at its end until the
// pending result has been transferred. Reports never clear the totals.
// Once the sample count is at its maximum, samples are dropped unchanged.
// Reset clears the sum, count, peak and any pending result.
module audio_rms_peak_level_meter #(
  parameter int SAMPLE_BITS = arplm_pkg::SAMPLE_BITS_DEF,
  parameter int TALLY_BITS  = arplm_pkg::TALLY_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  arplm_in_if.sink    in_ch,
  arplm_out_if.source out_ch
);
  arplm_pkg::cmd_t cmd;

  arplm_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .cmd      (cmd)
  );

  arplm_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TALLY_BITS (TALLY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample      (in_ch.sample),
    .rms_level   (out_ch.rms_level),
    .mean_square (out_ch.mean_square),
    .peak_level  (out_ch.peak_level),
    .sample_total(out_ch.sample_total)
  );
endmodule

/* rtl/core/arplm_ctrl.sv */
module arplm_ctrl #(
  parameter int SAMPLE_BITS = arplm_pkg::SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output arplm_pkg::cmd_t cmd
);
  localparam int MsBits = 2 * (SAMPLE_BITS - 1) + 1;
  localparam int CntBits = $clog2(MsBits + 1);

  arplm_pkg::state_t  state_r, state_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arplm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      arplm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == arplm_pkg::FUNC_REPORT) begin
            state_nxt = arplm_pkg::ST_DIV_LOAD;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      arplm_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = arplm_pkg::ST_DIV;
      end
      arplm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CntBits'(1);
        if (cnt_r == CntBits'(MsBits - 1)) begin
          state_nxt = arplm_pkg::ST_ROOT_LOAD;
        end
      end
      arplm_pkg::ST_ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = arplm_pkg::ST_ROOT;
      end
      arplm_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + CntBits'(1);
        if (cnt_r == CntBits'(SAMPLE_BITS - 1)) begin
          state_nxt = arplm_pkg::ST_DONE;
        end
      end
      arplm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = arplm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arplm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc, cmd.div_load, cmd.div_step, cmd.root_load, cmd.root_step, cmd.res_load}))
    else $error("more than one datapath command at once");
  a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");
  a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not presented");
endmodule

/* rtl/core/arplm_dp.sv */
module arplm_dp #(
  parameter int SAMPLE_BITS = arplm_pkg::SAMPLE_BITS_DEF,
  parameter int TALLY_BITS  = arplm_pkg::TALLY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arplm_pkg::cmd_t               cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0]        rms_level,
  output logic [2*(SAMPLE_BITS-1):0]    mean_square,
  output logic [SAMPLE_BITS-1:0]        peak_level,
  output logic [TALLY_BITS-1:0]         sample_total
);
  localparam int SB      = SAMPLE_BITS;
  localparam int TB      = TALLY_BITS;
  localparam int MsBits  = 2 * (SB - 1) + 1;
  localparam int SqBits  = 2 * SB - 1;
  localparam int SumBits = 2 * (SB - 1) + TB;
  localparam logic [SB-1:0] PeakMax = {1'b1, {(SB - 1){1'b0}}};

  logic [SumBits-1:0] sum_r, sum_nxt;
  logic [TB-1:0]      tally_r, tally_nxt;
  logic [SB-1:0]      peak_r, peak_nxt;
  logic [SqBits-1:0]  sq_r;
  logic               sq_vld_r;

  logic [SB-1:0]      mag;
  logic [2*SB-1:0]    prod;
  logic               tally_full;
  logic               take;

  logic [TB-1:0]      rem_r, dvs_r;
  logic [MsBits-1:0]  dlo_r;
  logic [SB-1:0]      pk_snap_r;
  logic [TB:0]        dtrial, ddiff;
  logic               dge;

  logic [2*SB-1:0]    rad_r;
  logic [SB-1:0]      root_r;
  logic [SB+1:0]      srem_r;
  logic [MsBits-1:0]  ms_snap_r;
  logic [SB+3:0]      st, strial, sdiff;
  logic               sge;

  logic [SB-1:0]      rms_r;
  logic [MsBits-1:0]  msq_r;
  logic [SB-1:0]      pko_r;
  logic [TB-1:0]      tot_r;

  assign mag        = sample[SB-1] ? (~sample + SB'(1)) : sample;
  assign prod       = {{SB{1'b0}}, mag} * {{SB{1'b0}}, mag};
  assign tally_full = &tally_r;
  assign take       = cmd.acc & ~tally_full;

  always_comb begin
    sum_nxt   = sq_vld_r ? (sum_r + SumBits'(sq_r)) : sum_r;
    tally_nxt = take ? (tally_r + TB'(1)) : tally_r;
    peak_nxt  = (take && (mag > peak_r)) ? mag : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      tally_r  <= '0;
      peak_r   <= '0;
      sq_vld_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      tally_r  <= tally_nxt;
      peak_r   <= peak_nxt;
      sq_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= prod[SqBits-1:0];
  end

  assign dtrial = {rem_r, dlo_r[MsBits-1]};
  assign ddiff  = dtrial - {1'b0, dvs_r};
  assign dge    = (dtrial >= {1'b0, dvs_r});

  assign st     = {2'b00, srem_r[SB-1:0], rad_r[2*SB-1:2*SB-2]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sdiff  = st - strial;
  assign sge    = (st >= strial);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r     <= TB'(sum_r[SumBits-1:MsBits]);
      dlo_r     <= sum_r[MsBits-1:0];
      dvs_r     <= tally_r;
      pk_snap_r <= peak_r;
    end else if (cmd.div_step) begin
      rem_r <= dge ? ddiff[TB-1:0] : dtrial[TB-1:0];
      dlo_r <= {dlo_r[MsBits-2:0], dge & (|dvs_r)};
    end
    if (cmd.root_load) begin
      rad_r     <= {1'b0, dlo_r};
      root_r    <= '0;
      srem_r    <= '0;
      ms_snap_r <= dlo_r;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[2*SB-3:0], 2'b00};
      root_r <= {root_r[SB-2:0], sge};
      srem_r <= sge ? sdiff[SB+1:0] : st[SB+1:0];
    end
    if (cmd.res_load) begin
      rms_r <= root_r;
      msq_r <= ms_snap_r;
      pko_r <= pk_snap_r;
      tot_r <= dvs_r;
    end
  end

  assign rms_level    = rms_r;
  assign mean_square  = msq_r;
  assign peak_level   = pko_r;
  assign sample_total = tot_r;

  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= PeakMax)
    else $error("peak beyond full-scale magnitude");
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (peak_r >= $past(peak_r)))
    else $error("peak decreased without reset");
  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((tally_r == $past(tally_r)) || (tally_r == $past(tally_r) + TB'(1))))
    else $error("sample count moved by more than one");
endmodule
